FILE: sv/dlp_pkg.sv
// ----------------------------------------------------------------------------
// Disk label parser package
// Constants of the label layout, the job passed from front to back, and the
// state type of the back sequencer.
// ----------------------------------------------------------------------------
package dlp_pkg;

  localparam logic [15:0] MAGIC_WORD  = 16'hDABE;
  localparam logic [3:0]  AUTO_SELECT = 4'd8;
  localparam int          SECTOR_SHIFT = 9;

  // Word positions within the 256-word label.
  localparam logic [7:0] POS_ID_FIRST   = 8'd71;
  localparam logic [7:0] POS_ID_LAST    = 8'd85;
  localparam logic [7:0] POS_TRACKS     = 8'd218;
  localparam logic [7:0] POS_SECTORS    = 8'd219;
  localparam logic [7:0] POS_PART_FIRST = 8'd222;
  localparam logic [7:0] POS_PART_LAST  = 8'd253;
  localparam logic [7:0] POS_MAGIC      = 8'd254;
  localparam logic [7:0] POS_LAST       = 8'd255;

  // Slots of the four words that describe one partition.
  localparam logic [1:0] SLOT_START_HI = 2'd0;
  localparam logic [1:0] SLOT_START_LO = 2'd1;
  localparam logic [1:0] SLOT_COUNT_HI = 2'd2;
  localparam logic [1:0] SLOT_COUNT_LO = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] secs;
    logic [15:0] tracks;
    logic [15:0] spt;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL1,
    BK_MUL2,
    BK_HOLD
  } back_state_t;

endpackage

FILE: sv/dlp_if.sv
// ----------------------------------------------------------------------------
// Disk label parser channels
// Valid/ready channels for label words and for parse results.
// ----------------------------------------------------------------------------
interface dlp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] label_word;
  logic        first_word;

  modport source (output valid, output label_word, output first_word, input ready);
  modport sink   (input valid, input label_word, input first_word, output ready);
endinterface

interface dlp_out_if;
  logic        valid;
  logic        ready;
  logic        label_valid;
  logic [2:0]  partition_index;
  logic [7:0]  partition_type;
  logic [63:0] byte_offset;
  logic [40:0] byte_size;

  modport source (output valid, output label_valid, output partition_index,
                  output partition_type, output byte_offset, output byte_size,
                  input ready);
  modport sink   (input valid, input label_valid, input partition_index,
                  input partition_type, input byte_offset, input byte_size,
                  output ready);
endinterface

FILE: sv/dlp_front.sv
// ----------------------------------------------------------------------------
// Disk label parser front
// Accepts label words, tracks position and checksum, captures the partition
// fields, and hands a finished job to the queue on the last word.
// ----------------------------------------------------------------------------
module dlp_front import dlp_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  dlp_in_if.sink         label_in,
  input  logic           queue_full,
  input  logic [3:0]     requested_partition,
  output logic           push,
  output job_t           job
);

  logic        accept;
  logic [7:0]  pos;
  logic [15:0] w;
  logic [7:0]  id_rel;
  logic [7:0]  part_rel;
  logic [2:0]  part;
  logic [1:0]  slot;
  logic        wants;
  logic [31:0] full;
  logic        id_write;

  logic [7:0]  word_position, word_position_next;
  logic [15:0] running_xor, running_xor_next;
  logic        magic_ok, magic_ok_next;
  logic [7:0]  partition_ids [8];
  logic [15:0] track_count, track_count_next;
  logic [15:0] sectors_per_track, sectors_per_track_next;
  logic [15:0] pending_high_half, pending_high_half_next;
  logic        chosen_found, chosen_found_next;
  logic [2:0]  chosen_index, chosen_index_next;
  logic [7:0]  chosen_type, chosen_type_next;
  logic [31:0] chosen_start_cylinder, chosen_start_cylinder_next;
  logic [31:0] chosen_sector_count, chosen_sector_count_next;
  logic [31:0] zero_start_cylinder, zero_start_cylinder_next;
  logic [31:0] zero_sector_count, zero_sector_count_next;

  assign label_in.ready = !queue_full;
  assign accept         = label_in.valid && !queue_full;
  assign w              = label_in.label_word;
  assign pos            = label_in.first_word ? 8'd0 : word_position;

  assign id_rel   = pos - POS_ID_FIRST;
  assign part_rel = pos - POS_PART_FIRST;
  assign part     = part_rel[4:2];
  assign slot     = part_rel[1:0];
  assign wants    = (requested_partition >= AUTO_SELECT) ||
                    (requested_partition == {1'b0, part});
  assign full     = {pending_high_half, w};
  assign id_write = (pos >= POS_ID_FIRST) && (pos <= POS_ID_LAST) && !id_rel[0];

  always_comb begin
    word_position_next         = pos + 8'd1;
    running_xor_next           = running_xor;
    magic_ok_next              = magic_ok;
    track_count_next           = track_count;
    sectors_per_track_next     = sectors_per_track;
    pending_high_half_next     = pending_high_half;
    chosen_found_next          = chosen_found;
    chosen_index_next          = chosen_index;
    chosen_type_next           = chosen_type;
    chosen_start_cylinder_next = chosen_start_cylinder;
    chosen_sector_count_next   = chosen_sector_count;
    zero_start_cylinder_next   = zero_start_cylinder;
    zero_sector_count_next     = zero_sector_count;

    // Position zero starts a fresh label.
    if (pos == 8'd0) begin
      running_xor_next           = '0;
      magic_ok_next              = 1'b0;
      track_count_next           = '0;
      sectors_per_track_next     = '0;
      pending_high_half_next     = '0;
      chosen_found_next          = 1'b0;
      chosen_index_next          = '0;
      chosen_type_next           = '0;
      chosen_start_cylinder_next = '0;
      chosen_sector_count_next   = '0;
      zero_start_cylinder_next   = '0;
      zero_sector_count_next     = '0;
    end

    running_xor_next = running_xor_next ^ w;

    if (pos == POS_TRACKS) begin
      track_count_next = w;
    end else if (pos == POS_SECTORS) begin
      sectors_per_track_next = w;
    end else if (pos >= POS_PART_FIRST && pos <= POS_PART_LAST) begin
      case (slot)
        SLOT_START_HI, SLOT_COUNT_HI: begin
          pending_high_half_next = w;
        end
        SLOT_START_LO: begin
          if (part == 3'd0) zero_start_cylinder_next = full;
          if (!chosen_found && wants) chosen_start_cylinder_next = full;
        end
        SLOT_COUNT_LO: begin
          if (part == 3'd0) zero_sector_count_next = full;
          if (!chosen_found && wants) begin
            chosen_sector_count_next = full;
            chosen_index_next        = part;
            chosen_type_next         = partition_ids[part];
            chosen_found_next        = (requested_partition < AUTO_SELECT) ||
                                       (full != 32'd0 && partition_ids[part] != 8'd0);
          end
        end
        default: begin
          pending_high_half_next = pending_high_half;
        end
      endcase
    end else if (pos == POS_MAGIC) begin
      magic_ok_next = (w == MAGIC_WORD);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position         <= '0;
      running_xor           <= '0;
      magic_ok              <= 1'b0;
      track_count           <= '0;
      sectors_per_track     <= '0;
      pending_high_half     <= '0;
      chosen_found          <= 1'b0;
      chosen_index          <= '0;
      chosen_type           <= '0;
      chosen_start_cylinder <= '0;
      chosen_sector_count   <= '0;
      zero_start_cylinder   <= '0;
      zero_sector_count     <= '0;
    end else if (accept) begin
      word_position         <= word_position_next;
      running_xor           <= running_xor_next;
      magic_ok              <= magic_ok_next;
      track_count           <= track_count_next;
      sectors_per_track     <= sectors_per_track_next;
      pending_high_half     <= pending_high_half_next;
      chosen_found          <= chosen_found_next;
      chosen_index          <= chosen_index_next;
      chosen_type           <= chosen_type_next;
      chosen_start_cylinder <= chosen_start_cylinder_next;
      chosen_sector_count   <= chosen_sector_count_next;
      zero_start_cylinder   <= zero_start_cylinder_next;
      zero_sector_count     <= zero_sector_count_next;
    end
  end

  // Ids are always written before a label reads them, so they need no reset.
  always_ff @(posedge clk) begin
    if (accept && id_write) begin
      partition_ids[id_rel[3:1]] <= w[7:0];
    end
  end

  always_comb begin
    push       = accept && (pos == POS_LAST);
    job.valid  = magic_ok && (running_xor_next == 16'd0);
    job.tracks = track_count;
    job.spt    = sectors_per_track;
    if (!job.valid) begin
      job.index = '0;
      job.ptype = '0;
      job.start = '0;
      job.secs  = '0;
    end else if (chosen_found) begin
      job.index = chosen_index;
      job.ptype = chosen_type;
      job.start = chosen_start_cylinder;
      job.secs  = chosen_sector_count;
    end else begin
      job.index = '0;
      job.ptype = partition_ids[0];
      job.start = zero_start_cylinder;
      job.secs  = zero_sector_count;
    end
  end

endmodule

FILE: sv/dlp_queue.sv
// ----------------------------------------------------------------------------
// Disk label parser job queue
// Short first-in first-out buffer of jobs between the front and the back.
// ----------------------------------------------------------------------------
module dlp_queue import dlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t pop_job,
  output logic full,
  output logic empty
);

  localparam int PtrWidth = $clog2(QUEUE_DEPTH);
  localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

  job_t                slots [QUEUE_DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CntWidth'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: sv/dlp_back.sv
// ----------------------------------------------------------------------------
// Disk label parser back end
// Takes one job from the queue, forms the byte offset with two registered
// multiplies, and holds the result until the receiver takes it.
// ----------------------------------------------------------------------------
module dlp_back import dlp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      queue_empty,
  input  job_t      queue_job,
  output logic      pop,
  dlp_out_if.source result_out
);

  back_state_t state, state_next;
  job_t        job_r;
  logic [47:0] prod1;
  logic [54:0] prod2;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!queue_empty) state_next = BK_MUL1;
      BK_MUL1: state_next = BK_MUL2;
      BK_MUL2: state_next = BK_HOLD;
      BK_HOLD: if (result_out.ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop              = (state == BK_IDLE) && !queue_empty;
    result_out.valid = (state == BK_HOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= queue_job;
    end
    if (state == BK_MUL1) begin
      prod1 <= 48'(job_r.start) * 48'(job_r.tracks);
    end
    if (state == BK_MUL2) begin
      // Only the low bits survive the final shift modulo 2^64.
      prod2 <= 55'(prod1) * 55'(job_r.spt);
    end
  end

  assign result_out.label_valid     = job_r.valid;
  assign result_out.partition_index = job_r.index;
  assign result_out.partition_type  = job_r.ptype;
  assign result_out.byte_offset     = {prod2, {SECTOR_SHIFT{1'b0}}};
  assign result_out.byte_size       = {job_r.secs, {SECTOR_SHIFT{1'b0}}};

endmodule

FILE: sv/disk_label_partition_parser.sv
// ----------------------------------------------------------------------------
// Disk label partition parser
// Parses a 256-word disk label and reports the selected partition's type,
// byte offset and byte size.
// ----------------------------------------------------------------------------
// Usage: label words enter on label_in, one item per cycle, big-endian 16-bit
// words in label order; first_word set on an item restarts the label at
// position zero, and the position otherwise wraps after the 256th word.
// The 256th word of every label produces exactly one item on result_out.
// A label whose magic word is wrong or whose words do not XOR to zero gives
// label_valid low with every other field zero.
// The partition is chosen by the register written through cfg_write and
// cfg_data: 0 to 7 picks that partition, 8 or more means automatic choice of
// the first partition with a nonzero id and sector count, else partition 0.
// Write it only between labels. It resets to automatic.
// Words are accepted one per cycle while label_in.ready is high. After the last
// word is accepted, the job is written to the queue; the back end takes it from
// the queue when it is idle, then does its two multiplies one after the other
// and presents the result.
// When the receiver stalls, the result is held stable; the two-entry job
// queue absorbs further labels, and label_in.ready falls only when both
// entries are full. Reset returns the block to position zero with an empty
// queue and no result pending.
// ----------------------------------------------------------------------------
module disk_label_partition_parser import dlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [3:0] cfg_data,
  dlp_in_if.sink     label_in,
  dlp_out_if.source  result_out
);

  // Requested partition; values above automatic are stored as automatic.
  logic [3:0] requested_partition;

  // Front to queue and queue to back.
  logic push;
  job_t push_job;
  logic queue_full;
  logic queue_empty;
  logic pop;
  job_t pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_partition <= AUTO_SELECT;
    end else if (cfg_write) begin
      requested_partition <= (cfg_data > AUTO_SELECT) ? AUTO_SELECT : cfg_data;
    end
  end

  // The front tracks position, checksum and partition fields word by word.
  dlp_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .label_in            (label_in),
    .queue_full          (queue_full),
    .requested_partition (requested_partition),
    .push                (push),
    .job                 (push_job)
  );

  // The queue lets the front keep taking words while a result is stalled.
  dlp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  // The back end does the offset arithmetic and drives the result channel.
  dlp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .queue_job   (pop_job),
    .pop         (pop),
    .result_out  (result_out)
  );

endmodule
